[hdl/erpf_pkg.sv]
// Package for the equal record pair finder: result kinds and controller states.
// No dependencies.
package erpf_pkg;

  localparam int unsigned IdxW = 6;

  typedef enum logic [1:0] {
    KIND_PAIR     = 2'd0,
    KIND_NONE     = 2'd1,
    KIND_OVERFLOW = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_FINISH,
    ST_EMIT
  } state_e;

  // IEEE double equality: +0 == -0, NaN never equal
  function automatic logic dbl_eq(input logic [63:0] x, input logic [63:0] y);
    logic x_nan;
    logic y_nan;
    logic x_zero;
    logic y_zero;
    x_nan  = (x[62:52] == 11'h7ff) && (x[51:0] != 52'd0);
    y_nan  = (y[62:52] == 11'h7ff) && (y[51:0] != 52'd0);
    x_zero = (x[62:0] == 63'd0);
    y_zero = (y[62:0] == 63'd0);
    return !x_nan && !y_nan && ((x == y) || (x_zero && y_zero));
  endfunction

endpackage

[hdl/equal_record_pair_finder_core.sv]
// Equal record pair finder: one record memory scanned per incoming record.
// Depends on erpf_pkg.
//
// Usage:
//  s_axis carries one record per beat. tdata = value_a, value_b, value_c
//  (192 bits); tuser = first_of_set, last_of_set.
//  m_axis carries results. tdata = kind, earlier_index, later_index (14 bits,
//  zero filled to 16); tlast = run_end.
//  A record with index n is compared with each stored record in the scan
//  (one memory read per stored record, read data registered in rd_q, the new
//  record written at the end of the scan), then closes out through ST_LAST,
//  ST_FINISH and ST_EMIT; s_axis_tready is high only in ST_IDLE, so no new
//  beat is taken until the record is done. Pair results leave during the scan,
//  each held back until the next match or the end of the scan settles its
//  tlast. An overflow record skips the scan; the no-match result may follow it.
//  Reset clears the record count and the match flag; memory contents stay
//  undefined and are never read before written within a set.
//  When the receiver stalls, the result is held in the output register and
//  the scan waits once a further result has to be placed.
module equal_record_pair_finder_core #(
  parameter int unsigned STORE_DEPTH = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [63:0] value_a, [127:64] value_b, [191:128] value_c
  input  logic [191:0] s_axis_tdata,
  // [0] first_of_set, [1] last_of_set
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [1:0] kind, [7:2] earlier_index, [13:8] later_index, [15:14] zero
  output logic [15:0]  m_axis_tdata,
  output logic         m_axis_tlast
);

  localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned IW = erpf_pkg::IdxW;

  logic [191:0] mem_q [STORE_DEPTH];
  logic [191:0] rd_q;
  logic [191:0] rec_q;
  logic         last_q;

  erpf_pkg::state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          seen_q, seen_d;
  logic [CW-1:0] scan_q, scan_d;   // address issued
  logic [CW-1:0] cmp_q, cmp_d;     // index of the entry in rd_q
  logic          rdv_q, rdv_d;
  logic          ovf_q, ovf_d;     // overflow still to emit
  logic          hp_v_q, hp_v_d;   // pair waiting until its tlast is known
  logic [IW-1:0] hp_e_q, hp_e_d;

  logic          out_v_q, out_v_d;
  logic [1:0]    out_k_q, out_k_d;
  logic [IW-1:0] out_e_q, out_e_d;
  logic [IW-1:0] out_l_q, out_l_d;
  logic          out_t_q, out_t_d;

  logic          accept;
  logic          wr_en;
  logic          rd_en;
  logic          match;
  logic          out_free;
  logic [CW-1:0] base_cnt;

  assign s_axis_tready = (state_q == erpf_pkg::ST_IDLE) && !out_v_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_v_q || m_axis_tready;
  assign base_cnt      = s_axis_tuser[0] ? '0 : count_q;

  assign match = erpf_pkg::dbl_eq(rd_q[63:0], rec_q[63:0]) &&
                 erpf_pkg::dbl_eq(rd_q[127:64], rec_q[127:64]) &&
                 erpf_pkg::dbl_eq(rd_q[191:128], rec_q[191:128]);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[count_q[AW-1:0]] <= rec_q;
    end
    if (rd_en) begin
      rd_q <= mem_q[scan_q[AW-1:0]];
    end
    if (accept) begin
      rec_q  <= s_axis_tdata;
      last_q <= s_axis_tuser[1];
    end
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    seen_d  = seen_q;
    scan_d  = scan_q;
    cmp_d   = cmp_q;
    rdv_d   = 1'b0;
    ovf_d   = ovf_q;
    hp_v_d  = hp_v_q;
    hp_e_d  = hp_e_q;
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    out_v_d = out_v_q && !m_axis_tready;
    out_k_d = out_k_q;
    out_e_d = out_e_q;
    out_l_d = out_l_q;
    out_t_d = out_t_q;
    case (state_q)
      erpf_pkg::ST_IDLE: begin
        if (accept) begin
          count_d = base_cnt;
          if (s_axis_tuser[0]) seen_d = 1'b0;
          scan_d  = '0;
          ovf_d   = (base_cnt >= CW'(STORE_DEPTH));
          state_d = ovf_d ? erpf_pkg::ST_LAST : erpf_pkg::ST_SCAN;
        end
      end
      erpf_pkg::ST_SCAN: begin
        // hold everything while a held pair cannot be pushed out
        if (!(rdv_q && match && hp_v_q && !out_free)) begin
          if (rdv_q && match) begin
            seen_d = 1'b1;
            hp_v_d = 1'b1;
            hp_e_d = IW'(cmp_q);
            if (hp_v_q) begin
              out_v_d = 1'b1;
              out_k_d = erpf_pkg::KIND_PAIR;
              out_e_d = hp_e_q;
              out_l_d = IW'(count_q);
              out_t_d = 1'b0;
            end
          end
          if (scan_q < count_q) begin
            rd_en  = 1'b1;
            rdv_d  = 1'b1;
            cmp_d  = scan_q;
            scan_d = scan_q + 1'b1;
          end else begin
            wr_en   = 1'b1;
            count_d = count_q + 1'b1;
            state_d = erpf_pkg::ST_LAST;
          end
        end else begin
          rdv_d = rdv_q;
        end
      end
      erpf_pkg::ST_LAST: begin
        // emit the held pair or the overflow, then the no-match result
        if (out_free) begin
          if (hp_v_q) begin
            hp_v_d  = 1'b0;
            out_v_d = 1'b1;
            out_k_d = erpf_pkg::KIND_PAIR;
            out_e_d = hp_e_q;
            out_l_d = IW'(count_q - 1'b1);
            out_t_d = 1'b1;
          end else if (ovf_q) begin
            ovf_d   = 1'b0;
            out_v_d = 1'b1;
            out_k_d = erpf_pkg::KIND_OVERFLOW;
            out_e_d = '0;
            out_l_d = '0;
            out_t_d = !(last_q && !seen_q);
          end else if (last_q && !seen_q) begin
            out_v_d = 1'b1;
            out_k_d = erpf_pkg::KIND_NONE;
            out_e_d = '0;
            out_l_d = '0;
            out_t_d = 1'b1;
          end
          if (!ovf_q || !(last_q && !seen_q)) begin
            state_d = erpf_pkg::ST_FINISH;
          end
        end
      end
      erpf_pkg::ST_FINISH: begin
        if (last_q) begin
          count_d = '0;
          seen_d  = 1'b0;
        end
        state_d = erpf_pkg::ST_EMIT;
      end
      erpf_pkg::ST_EMIT: begin
        if (out_free) state_d = erpf_pkg::ST_IDLE;
      end
      default: state_d = erpf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= erpf_pkg::ST_IDLE;
      count_q <= '0;
      seen_q  <= 1'b0;
      scan_q  <= '0;
      cmp_q   <= '0;
      rdv_q   <= 1'b0;
      ovf_q   <= 1'b0;
      hp_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      seen_q  <= seen_d;
      scan_q  <= scan_d;
      cmp_q   <= cmp_d;
      rdv_q   <= rdv_d;
      ovf_q   <= ovf_d;
      hp_v_q  <= hp_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hp_e_q  <= hp_e_d;
    out_k_q <= out_k_d;
    out_e_q <= out_e_d;
    out_l_q <= out_l_d;
    out_t_q <= out_t_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {2'b00, out_l_q, out_e_q, out_k_q};
  assign m_axis_tlast  = out_t_q;

endmodule
